// ===== rtl/jaq_pkg.sv =====
// Shared types and constants of the joystick axis quantizer.
package jaq_pkg;

  localparam int DzW = 10;
  localparam int StepW = 8;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [DzW-1:0] DeadZoneReset = 10'd64;
  localparam logic [StepW-1:0] StepCountReset = 8'd4;

  typedef enum logic {
    RegDeadZone = 1'b0,
    RegStepCount = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DzW-1:0] dead_zone;
    logic [StepW-1:0] step_count;
  } cfg_t;

endpackage

// ===== rtl/jaq_front.sv =====
// Front end: accepts samples, classifies side and dead zone, forms the scaled numerator.
module jaq_front import jaq_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     mode_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_active_o,
  output logic [SAMPLE_BITS+StepW-1:0] out_num_o,
  output logic [SAMPLE_BITS-1:0]   out_span_o
);

  localparam int CmpW = (SAMPLE_BITS > DzW) ? SAMPLE_BITS : DzW;
  localparam int NumW = SAMPLE_BITS + StepW;
  localparam logic [SAMPLE_BITS-1:0] Center = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                   side_ok;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] dz_s;
  logic                   act_d;
  logic [SAMPLE_BITS-1:0] diff_d;
  logic [SAMPLE_BITS-1:0] span_d;
  logic [NumW-1:0]        num_d;
  logic                   ready1;

  logic                   v1_q, act1_q;
  logic [SAMPLE_BITS-1:0] diff1_q, span1_q;
  logic                   v2_q, act2_q;
  logic [NumW-1:0]        num2_q;
  logic [SAMPLE_BITS-1:0] span2_q;

  always_comb begin
    side_ok = mode_i ? (sample_i > Center) : (sample_i < Center);
    mag = mode_i ? (sample_i - Center) : (Center - sample_i);
    dz_s = SAMPLE_BITS'(cfg_i.dead_zone);
    act_d = side_ok && (CmpW'(mag) > CmpW'(cfg_i.dead_zone));
    diff_d = act_d ? (mag - dz_s) : '0;
    span_d = act_d ? (Center - dz_s) : SAMPLE_BITS'(1);
    num_d = NumW'(diff1_q) * NumW'(cfg_i.step_count) + NumW'(span1_q) - NumW'(1);
  end

  assign ready1 = !v2_q || out_ready_i;
  assign in_ready_o = !v1_q || ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (ready1) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act1_q <= act_d;
      diff1_q <= diff_d;
      span1_q <= span_d;
    end
    if (v1_q && ready1) begin
      act2_q <= act1_q;
      num2_q <= num_d;
      span2_q <= span1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_active_o = act2_q;
  assign out_num_o = num2_q;
  assign out_span_o = span2_q;

endmodule

// ===== rtl/jaq_fifo.sv =====
// Two-entry queue between the front end and the divider.
module jaq_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_data_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem[wr_ptr_q] <= in_data_i;
  end

endmodule

// ===== rtl/jaq_div.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage.
module jaq_div import jaq_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_active_i,
  input  logic [SAMPLE_BITS+StepW-1:0] in_num_i,
  input  logic [SAMPLE_BITS-1:0]       in_span_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         active_o,
  output logic [StepW-1:0]             step_o
);

  localparam int NumW = SAMPLE_BITS + StepW;

  logic                   v_q    [StepW];
  logic                   act_q  [StepW];
  logic [NumW-1:0]        rem_q  [StepW];
  logic [SAMPLE_BITS-1:0] span_q [StepW];
  logic [StepW-1:0]       quo_q  [StepW];

  logic                   src_v    [StepW];
  logic                   src_act  [StepW];
  logic [NumW-1:0]        src_rem  [StepW];
  logic [SAMPLE_BITS-1:0] src_span [StepW];
  logic [StepW-1:0]       src_quo  [StepW];
  logic [NumW-1:0]        rem_d    [StepW];
  logic [StepW-1:0]       quo_d    [StepW];
  logic                   rdy      [StepW+1];

  always_comb begin
    rdy[StepW] = out_ready_i;
    for (int j = StepW - 1; j >= 0; j--) begin
      rdy[j] = !v_q[j] || rdy[j+1];
    end
    for (int j = 0; j < StepW; j++) begin
      if (j == 0) begin
        src_v[j] = in_valid_i;
        src_act[j] = in_active_i;
        src_rem[j] = in_num_i;
        src_span[j] = in_span_i;
        src_quo[j] = '0;
      end else begin
        src_v[j] = v_q[j-1];
        src_act[j] = act_q[j-1];
        src_rem[j] = rem_q[j-1];
        src_span[j] = span_q[j-1];
        src_quo[j] = quo_q[j-1];
      end
      if (src_rem[j] >= (NumW'(src_span[j]) << (StepW - 1 - j))) begin
        rem_d[j] = src_rem[j] - (NumW'(src_span[j]) << (StepW - 1 - j));
        quo_d[j] = src_quo[j] | (StepW'(1) << (StepW - 1 - j));
      end else begin
        rem_d[j] = src_rem[j];
        quo_d[j] = src_quo[j];
      end
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < StepW; j++) v_q[j] <= 1'b0;
    end else begin
      for (int j = 0; j < StepW; j++) begin
        if (rdy[j]) v_q[j] <= src_v[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < StepW; j++) begin
      if (src_v[j] && rdy[j]) begin
        act_q[j] <= src_act[j];
        rem_q[j] <= rem_d[j];
        span_q[j] <= src_span[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign out_valid_o = v_q[StepW-1];
  assign active_o = act_q[StepW-1];
  assign step_o = quo_q[StepW-1];

endmodule

// ===== rtl/joystick_axis_quantizer.sv =====
// Top level of the joystick axis quantizer with its register port.
// Each input item is one axis sample and the side asked about; each item yields
// exactly one result item with the active flag and the quantized step.
// Both channels use valid and ready; an item moves when both are high.
// Registers: dead_zone at address 0 and step_count at address 4, written and
// read through the APB-style port, which never waits.
// With no stalls a result item passes through two front-end stages, the
// two-entry queue and eight divider stages, one quotient bit each.
// Throughput is one item per cycle while the receiver keeps its ready high.
// Every stage holds its item while the next one is full, so a stalled receiver
// fills the pipeline and the queue before input ready drops.
// Reset empties all stages and the queue and sets dead_zone to 64 and
// step_count to 4.
module joystick_axis_quantizer import jaq_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   mode_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   active_o,
  output logic [StepW-1:0]       step_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0]    pwdata,
  output logic [ApbDataW-1:0]    prdata,
  output logic                   pready
);

  localparam int NumW = SAMPLE_BITS + StepW;
  localparam int QW = 1 + NumW + SAMPLE_BITS;

  cfg_t cfg_q;
  reg_idx_e reg_sel;

  logic                   f_valid, f_ready, f_active;
  logic [NumW-1:0]        f_num;
  logic [SAMPLE_BITS-1:0] f_span;
  logic                   q_valid, q_ready;
  logic [QW-1:0]          q_data;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone <= DeadZoneReset;
      cfg_q.step_count <= StepCountReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        RegDeadZone:  cfg_q.dead_zone <= pwdata[DzW-1:0];
        RegStepCount: cfg_q.step_count <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegDeadZone:  prdata = ApbDataW'(cfg_q.dead_zone);
      RegStepCount: prdata = ApbDataW'(cfg_q.step_count);
      default:      prdata = '0;
    endcase
  end

  jaq_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .mode_i       (mode_i),
    .out_valid_o  (f_valid),
    .out_ready_i  (f_ready),
    .out_active_o (f_active),
    .out_num_o    (f_num),
    .out_span_o   (f_span)
  );

  jaq_fifo #(.Width(QW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_active, f_num, f_span}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  jaq_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_active_i (q_data[QW-1]),
    .in_num_i    (q_data[QW-2:SAMPLE_BITS]),
    .in_span_i   (q_data[SAMPLE_BITS-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .active_o    (active_o),
    .step_o      (step_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench of the joystick axis quantizer: directed and random samples checked in order.
`timescale 1ns / 100ps

module testbench;
  import jaq_pkg::*;

  localparam int SampleBits = 10;
  localparam int unsigned Center = 1 << (SampleBits - 1);
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic             active;
    logic [StepW-1:0] step;
  } axis_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SampleBits-1:0] sample_i = '0;
  logic                  mode_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  active_o;
  logic [StepW-1:0]      step_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ApbAddrW-1:0]   paddr = '0;
  logic [ApbDataW-1:0]   pwdata = '0;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  logic [DzW-1:0]   dz_cfg = DeadZoneReset;
  logic [StepW-1:0] steps_cfg = StepCountReset;
  axis_result_t     pending_results[$];
  bit               idle_en = 1'b1;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  int               mismatches = 0;
  int               samples_sent = 0;
  int               results_checked = 0;
  int               active_seen = 0;
  int               settings_used = 0;

  joystick_axis_quantizer #(
    .SAMPLE_BITS(SampleBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .active_o   (active_o),
    .step_o     (step_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic axis_result_t quantize_axis(logic [SampleBits-1:0] raw, logic positive);
    axis_result_t res;
    int unsigned  mag;
    int unsigned  dz;
    int unsigned  span;
    int unsigned  q;
    logic         on_side;
    res = '0;
    mag = 0;
    dz = int'(dz_cfg);
    if (positive) begin
      on_side = raw > Center;
      if (on_side) mag = raw - Center;
    end else begin
      on_side = raw < Center;
      if (on_side) mag = Center - raw;
    end
    if (on_side && mag > dz) begin
      if (mag > Center) mag = Center;
      span = Center - dz;
      q = ((mag - dz) * int'(steps_cfg) + span - 1) / span;
      if (q < 1) q = 1;
      if (q > int'(steps_cfg)) q = int'(steps_cfg);
      res.active = 1'b1;
      res.step = q[StepW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    axis_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected, active %0b step %0d",
                 $time, active_o, step_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (active_o !== want.active) begin
          $display("%0t: active mismatch, expected %0b, got %0b", $time, want.active, active_o);
          mismatches++;
        end
        if (step_o !== want.step) begin
          $display("%0t: step mismatch, expected %0d, got %0d", $time, want.step, step_o);
          mismatches++;
        end
        if (want.active) active_seen <= active_seen + 1;
      end
      results_checked <= results_checked + 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SampleBits-1:0] raw, input logic positive);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= raw;
    mode_i <= positive;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(quantize_axis(raw, positive));
    samples_sent++;
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == RegDeadZone) dz_cfg = value[DzW-1:0];
    else steps_cfg = value[StepW-1:0];
    @(posedge clk_i);
  endtask

  task automatic apb_check(input reg_idx_e idx, input logic [ApbDataW-1:0] want);
    logic [ApbDataW-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ApbAddrW'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %s readback mismatch, expected %0d, got %0d",
               $time, idx.name(), want, got);
      mismatches++;
    end
    @(posedge clk_i);
  endtask

  // The block must be empty before its registers change.
  task automatic set_config(input logic [DzW-1:0] dz, input logic [StepW-1:0] steps);
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    apb_write(RegDeadZone, ApbDataW'(dz));
    apb_write(RegStepCount, ApbDataW'(steps));
    apb_check(RegDeadZone, ApbDataW'(dz));
    apb_check(RegStepCount, ApbDataW'(steps));
    settings_used++;
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 1023;
          2: v = Center - 1;
          3: v = Center + 1;
          default: v = Center;
        endcase
      end
      1, 2, 3: begin
        v = int'(dz_cfg) + $urandom_range(0, 3) - 1;
        v = $urandom_range(0, 1) ? int'(Center) + v : int'(Center) - v;
      end
      4, 5: v = int'(Center) + $urandom_range(0, 20) - 10;
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SampleBits-1:0];
  endfunction

  task automatic test_reset_setting();
    apb_check(RegDeadZone, ApbDataW'(DeadZoneReset));
    apb_check(RegStepCount, ApbDataW'(StepCountReset));
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd512, 1'b0);
    send_sample(10'd512, 1'b1);
    send_sample(10'd0, 1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd448, 1'b0);
    send_sample(10'd447, 1'b0);
    send_sample(10'd576, 1'b1);
    send_sample(10'd577, 1'b1);
  endtask

  task automatic test_extreme_settings();
    set_config(10'd0, 8'd255);
    send_sample(10'd511, 1'b0);
    send_sample(10'd513, 1'b1);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);
    set_config(10'd512, 8'd255);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);
    set_config(10'd1023, 8'd1);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);
    // A zero step count still reports the axis as active, with step zero.
    set_config(10'd0, 8'd0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd700, 1'b1);
    set_config(10'd511, 8'd1);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1, 1'b0);
    send_sample(10'd1023, 1'b1);
  endtask

  task automatic test_random_settings();
    logic [DzW-1:0]   dz;
    logic [StepW-1:0] steps;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: dz = 10'd0;
        1: dz = 10'd512;
        2: dz = 10'd511;
        default: dz = DzW'($urandom_range(0, 512));
      endcase
      case ($urandom_range(0, 7))
        0: steps = 8'd1;
        1: steps = 8'd255;
        2: steps = 8'd0;
        default: steps = StepW'($urandom_range(1, 255));
      endcase
      set_config(dz, steps);
      for (int n = 0; n < 60; n++) begin
        if (phase == 3 && n == 30) wait_results();
        send_sample(pick_sample(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_back_to_back();
    set_config(DzW'($urandom_range(0, 200)), StepW'($urandom_range(1, 255)));
    idle_en = 1'b0;
    for (int n = 0; n < 100; n++) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_setting();
    test_extreme_settings();
    test_random_settings();
    test_back_to_back();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d results of %0d samples (%0d active) over %0d register settings.",
             results_checked, samples_sent, active_seen, settings_used);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
